// ===== rtl/core/gbn_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the go-back-n sender window.
// No dependencies; imported by gbn_ctrl, gbn_emit and the top level.
package gbn_pkg;

    localparam int DEF_BUFFER_DEPTH = 64;
    localparam int DEF_WINDOW_MAX   = 16;

    localparam int ID_W     = 32;
    localparam int HANDLE_W = 16;
    localparam int LENGTH_W = 8;
    localparam int DESC_W   = HANDLE_W + LENGTH_W;
    localparam int WIN_W    = 5;

    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(16);
    localparam logic [ID_W-1:0]  ID_RESET     = ID_W'(1);

    typedef enum logic [1:0] {
        CMD_NEW     = 2'd0,
        CMD_ACK     = 2'd1,
        CMD_TIMEOUT = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PLAN,
        ST_RUN,
        ST_DRAIN
    } t_state;

    // One result on its way from the controller to the output stage.
    typedef struct packed {
        logic            valid;
        logic            kind;
        logic [ID_W-1:0] id;
        logic            start;
        logic            stop;
        logic            drop;
        logic            last;
    } t_item;

endpackage

// ===== rtl/core/gbn_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module gbn_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/gbn_ctrl.sv =====
`timescale 1ns / 1ps
// Window controller: id pointers, descriptor writes, send planning and read issue.
// Depends on gbn_pkg.
module gbn_ctrl import gbn_pkg::*; #(
    parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH,
    parameter int WINDOW_MAX   = DEF_WINDOW_MAX,
    localparam int AW          = $clog2(BUFFER_DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_cmd,
    input  logic [HANDLE_W-1:0] i_payload_handle,
    input  logic [LENGTH_W-1:0] i_payload_length,
    input  logic [ID_W-1:0]     i_ack_id,
    input  logic                i_ack_ok,
    input  logic                i_cfg_valid,
    input  logic [WIN_W-1:0]    i_cfg_window_size,
    input  logic                i_out_last,
    output logic                o_ram_we,
    output logic [AW-1:0]       o_ram_waddr,
    output logic [DESC_W-1:0]   o_ram_wdata,
    output logic                o_ram_re,
    output logic [AW-1:0]       o_ram_raddr,
    output t_item               o_item
);

    localparam int CNTW = $clog2(WINDOW_MAX + 1);
    localparam int WEFF = (WINDOW_MAX < BUFFER_DEPTH) ? WINDOW_MAX : BUFFER_DEPTH;

    t_state              r_state, n_state;
    logic [WIN_W-1:0]    r_window, n_window;
    logic [ID_W-1:0]     r_base, n_base;
    logic [ID_W-1:0]     r_send, n_send;
    logic [ID_W-1:0]     r_create, n_create;
    logic [AW-1:0]       r_head, n_head;
    logic                r_refill, n_refill;
    logic                r_resend, n_resend;
    logic                r_stop, n_stop;
    logic                r_drop, n_drop;
    logic [ID_W-1:0]     r_cur, n_cur;
    logic [AW-1:0]       r_slot, n_slot;
    logic [CNTW-1:0]     r_cnt, n_cnt;
    logic                r_first, n_first;
    logic                r_first_start, n_first_start;

    // latched command transaction
    t_cmd                r_cmd;
    logic [HANDLE_W-1:0] r_handle;
    logic [LENGTH_W-1:0] r_length;
    logic [ID_W-1:0]     r_ack;
    logic                r_ok;

    logic [ID_W-1:0]     create_off, adv, outst, avail, start_id, start_off;
    logic                full, ack_good;
    logic [CNTW-1:0]     eff_w, room, refill_cnt, resend_cnt, plan_cnt;

    function automatic logic [AW-1:0] wrap_slot(input logic [AW:0] s);
        if (s >= (AW+1)'(BUFFER_DEPTH)) begin
            return AW'(s - (AW+1)'(BUFFER_DEPTH));
        end
        return s[AW-1:0];
    endfunction

    always_comb begin
        if (r_window == '0) begin
            eff_w = CNTW'(1);
        end else if (32'(r_window) > 32'(WEFF)) begin
            eff_w = CNTW'(WEFF);
        end else begin
            eff_w = CNTW'(r_window);
        end
    end

    assign create_off = r_create - r_base;
    assign full       = create_off >= 32'(BUFFER_DEPTH);
    assign adv        = r_ack - r_base + 32'd1;
    assign outst      = r_send - r_base;
    assign ack_good   = r_ok && (adv != '0) && (adv <= outst);
    assign avail      = r_create - r_send;

    assign room       = (outst < 32'(eff_w)) ? (eff_w - outst[CNTW-1:0]) : '0;
    assign refill_cnt = (avail < 32'(room)) ? avail[CNTW-1:0] : room;
    assign resend_cnt = (outst < 32'(WINDOW_MAX)) ? outst[CNTW-1:0] : CNTW'(WINDOW_MAX);
    assign plan_cnt   = r_refill ? refill_cnt : (r_resend ? resend_cnt : '0);
    assign start_id   = r_resend ? r_base : r_send;
    assign start_off  = start_id - r_base;

    always_comb begin
        n_state       = r_state;
        n_window      = r_window;
        n_base        = r_base;
        n_send        = r_send;
        n_create      = r_create;
        n_head        = r_head;
        n_refill      = r_refill;
        n_resend      = r_resend;
        n_stop        = r_stop;
        n_drop        = r_drop;
        n_cur         = r_cur;
        n_slot        = r_slot;
        n_cnt         = r_cnt;
        n_first       = r_first;
        n_first_start = r_first_start;
        o_ram_we      = 1'b0;
        o_ram_waddr   = wrap_slot({1'b0, r_head} + create_off[AW:0]);
        o_ram_wdata   = {r_handle, r_length};
        o_ram_re      = 1'b0;
        o_ram_raddr   = r_slot;
        o_item        = '0;

        if (i_cfg_valid) begin
            n_window = i_cfg_window_size;
        end

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_refill = 1'b0;
                n_resend = 1'b0;
                n_stop   = 1'b0;
                n_drop   = 1'b0;
                case (r_cmd)
                    CMD_NEW: begin
                        if (full) begin
                            n_drop = 1'b1;
                        end else begin
                            o_ram_we = 1'b1;
                            n_create = r_create + 32'd1;
                            n_refill = 1'b1;
                        end
                    end
                    CMD_ACK: begin
                        if (ack_good) begin
                            n_head   = wrap_slot({1'b0, r_head} + adv[AW:0]);
                            n_base   = r_ack + 32'd1;
                            n_stop   = (r_ack + 32'd1) == r_send;
                            n_refill = 1'b1;
                        end
                    end
                    CMD_TIMEOUT: begin
                        n_resend = 1'b1;
                    end
                    default: begin
                    end
                endcase
                n_state = ST_PLAN;
            end
            ST_PLAN: begin
                n_cur         = start_id;
                n_slot        = wrap_slot({1'b0, r_head} + start_off[AW:0]);
                n_cnt         = plan_cnt;
                n_first       = 1'b1;
                n_first_start = r_resend || (r_send == r_base);
                if (r_refill) begin
                    n_send = r_send + 32'(plan_cnt);
                end
                if (plan_cnt == '0) begin
                    // nothing to transmit: one status result
                    o_item.valid = 1'b1;
                    o_item.start = r_resend;
                    o_item.stop  = r_stop;
                    o_item.drop  = r_drop;
                    o_item.last  = 1'b1;
                    n_state      = ST_DRAIN;
                end else begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                o_ram_re     = 1'b1;
                o_item.valid = 1'b1;
                o_item.kind  = 1'b1;
                o_item.id    = r_cur;
                o_item.start = r_first && r_first_start;
                o_item.stop  = r_first && r_stop;
                o_item.last  = r_cnt == CNTW'(1);
                n_cur        = r_cur + 32'd1;
                n_slot       = (r_slot == AW'(BUFFER_DEPTH - 1)) ? '0 : r_slot + AW'(1);
                n_cnt        = r_cnt - CNTW'(1);
                n_first      = 1'b0;
                if (r_cnt == CNTW'(1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_out_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_window      <= WINDOW_RESET;
            r_base        <= ID_RESET;
            r_send        <= ID_RESET;
            r_create      <= ID_RESET;
            r_head        <= '0;
            r_refill      <= 1'b0;
            r_resend      <= 1'b0;
            r_stop        <= 1'b0;
            r_drop        <= 1'b0;
            r_cnt         <= '0;
            r_first       <= 1'b0;
            r_first_start <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_window      <= n_window;
            r_base        <= n_base;
            r_send        <= n_send;
            r_create      <= n_create;
            r_head        <= n_head;
            r_refill      <= n_refill;
            r_resend      <= n_resend;
            r_stop        <= n_stop;
            r_drop        <= n_drop;
            r_cnt         <= n_cnt;
            r_first       <= n_first;
            r_first_start <= n_first_start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur  <= n_cur;
        r_slot <= n_slot;
        if (r_state == ST_IDLE && start) begin
            r_cmd    <= t_cmd'(i_cmd);
            r_handle <= i_payload_handle;
            r_length <= i_payload_length;
            r_ack    <= i_ack_id;
            r_ok     <= i_ack_ok;
        end
    end

    assign busy = r_state != ST_IDLE;

endmodule

// ===== rtl/core/gbn_emit.sv =====
`timescale 1ns / 1ps
// Output stage: aligns items with descriptor read data and registers the result ports.
// Depends on gbn_pkg.
module gbn_emit import gbn_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_item               i_item,
    input  logic [DESC_W-1:0]   i_rdata,
    output logic                o_strobe,
    output logic                o_out_kind,
    output logic [ID_W-1:0]     o_send_id,
    output logic [HANDLE_W-1:0] o_send_handle,
    output logic [LENGTH_W-1:0] o_send_length,
    output logic                o_timer_start,
    output logic                o_timer_stop,
    output logic                o_dropped,
    output logic                o_last
);

    t_item               r_pipe;
    logic                r_strobe;
    logic                r_kind;
    logic [ID_W-1:0]     r_id;
    logic [HANDLE_W-1:0] r_handle;
    logic [LENGTH_W-1:0] r_length;
    logic                r_start, r_stop, r_drop, r_last;

    // read data lands in the cycle after the item, together with r_pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe.valid <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_pipe.valid <= i_item.valid;
            r_strobe     <= r_pipe.valid;
        end
        r_pipe.kind  <= i_item.kind;
        r_pipe.id    <= i_item.id;
        r_pipe.start <= i_item.start;
        r_pipe.stop  <= i_item.stop;
        r_pipe.drop  <= i_item.drop;
        r_pipe.last  <= i_item.last;
        r_kind       <= r_pipe.kind;
        r_id         <= r_pipe.kind ? r_pipe.id : '0;
        r_handle     <= r_pipe.kind ? i_rdata[DESC_W-1:LENGTH_W] : '0;
        r_length     <= r_pipe.kind ? i_rdata[LENGTH_W-1:0] : '0;
        r_start      <= r_pipe.start;
        r_stop       <= r_pipe.stop;
        r_drop       <= r_pipe.drop;
        r_last       <= r_pipe.last;
    end

    assign o_strobe      = r_strobe;
    assign o_out_kind    = r_kind;
    assign o_send_id     = r_id;
    assign o_send_handle = r_handle;
    assign o_send_length = r_length;
    assign o_timer_start = r_start;
    assign o_timer_stop  = r_stop;
    assign o_dropped     = r_drop;
    assign o_last        = r_last;

endmodule

// ===== rtl/core/go_back_n_sender_window.sv =====
`timescale 1ns / 1ps
// Go-back-n sender window: top level with descriptor store, controller, output stage.
// Depends on gbn_pkg, gbn_ram, gbn_ctrl, gbn_emit.
//
// Usage:
//   Command channel: a transaction is taken at a clock edge with start high and
//   busy low. i_cmd selects new packet, ack or timeout; the other fields are
//   used by the command that needs them.
//   Results: one per cycle while o_strobe is high, o_last marks the final one of
//   a command. The receiver cannot stall; results are never held back.
//   Config: i_cfg_window_size is written when i_cfg_valid is high (o_cfg_ready is
//   always high); write it only while busy is low.
//   Flow: a taken command passes through the execute and plan states; a status-only
//   result is formed in the plan state, sent packets in the run state, and each result
//   then passes the output stage's item register and result registers. busy drops the
//   cycle after the last result. A command sends at most WINDOW_MAX packets, read through
//   the single descriptor read port, one descriptor per cycle.
//   Reset: ids restart at 1, nothing is buffered, window size is 16. The
//   descriptor store is not cleared; entries are written before they are read.
module go_back_n_sender_window import gbn_pkg::*; #(
    parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH,
    parameter int WINDOW_MAX   = DEF_WINDOW_MAX
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_cmd,
    input  logic [HANDLE_W-1:0] i_payload_handle,
    input  logic [LENGTH_W-1:0] i_payload_length,
    input  logic [ID_W-1:0]     i_ack_id,
    input  logic                i_ack_ok,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [WIN_W-1:0]    i_cfg_window_size,
    output logic                o_strobe,
    output logic                o_out_kind,
    output logic [ID_W-1:0]     o_send_id,
    output logic [HANDLE_W-1:0] o_send_handle,
    output logic [LENGTH_W-1:0] o_send_length,
    output logic                o_timer_start,
    output logic                o_timer_stop,
    output logic                o_dropped,
    output logic                o_last
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic              w_ram_we, w_ram_re;
    logic [AW-1:0]     w_ram_waddr, w_ram_raddr;
    logic [DESC_W-1:0] w_ram_wdata, w_ram_rdata;
    t_item             w_item;

    assign o_cfg_ready = 1'b1;

    gbn_ram #(
        .WIDTH (DESC_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    gbn_ctrl #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .WINDOW_MAX   (WINDOW_MAX)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_cmd             (i_cmd),
        .i_payload_handle  (i_payload_handle),
        .i_payload_length  (i_payload_length),
        .i_ack_id          (i_ack_id),
        .i_ack_ok          (i_ack_ok),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_window_size (i_cfg_window_size),
        .i_out_last        (o_strobe && o_last),
        .o_ram_we          (w_ram_we),
        .o_ram_waddr       (w_ram_waddr),
        .o_ram_wdata       (w_ram_wdata),
        .o_ram_re          (w_ram_re),
        .o_ram_raddr       (w_ram_raddr),
        .o_item            (w_item)
    );

    gbn_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (w_item),
        .i_rdata       (w_ram_rdata),
        .o_strobe      (o_strobe),
        .o_out_kind    (o_out_kind),
        .o_send_id     (o_send_id),
        .o_send_handle (o_send_handle),
        .o_send_length (o_send_length),
        .o_timer_start (o_timer_start),
        .o_timer_stop  (o_timer_stop),
        .o_dropped     (o_dropped),
        .o_last        (o_last)
    );

`ifndef SYNTHESIS
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe outside a command");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !busy)
        else $error("busy held after last result");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_strobe))
        else $error("command transaction not held busy");

    a_read_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_re |-> (w_item.valid && w_item.kind && !w_ram_we))
        else $error("descriptor read without send item");
`endif

endmodule

// ===== dv/tb_go_back_n_sender_window.sv =====
`timescale 1ns / 1ps
// Self-checking bench for go_back_n_sender_window: directed plan, then random traffic.
// A shadow window tracker predicts results not written in the plan; depends on gbn_pkg and the RTL top.
module tb_go_back_n_sender_window;
    import gbn_pkg::*;

    localparam int          BUF_DEPTH   = DEF_BUFFER_DEPTH;
    localparam int          WIN_MAX     = DEF_WINDOW_MAX;
    localparam logic [1:0]  CMD_UNKNOWN = 2'd3;
    localparam int          MAX_GAP     = 12;
    localparam int          DRAIN_WAIT  = 25;
    localparam int          TARGET      = 330;

    typedef struct packed {
        logic                kind;
        logic [ID_W-1:0]     id;
        logic [HANDLE_W-1:0] handle;
        logic [LENGTH_W-1:0] length;
        logic                tstart;
        logic                tstop;
        logic                drop;
        logic                last;
    } t_result;

    typedef struct packed {
        logic                cfg;   // register write instead of a command
        logic [WIN_W-1:0]    win;
        logic [1:0]          cmd;
        logic [HANDLE_W-1:0] hnd;
        logic [LENGTH_W-1:0] len;
        logic [ID_W-1:0]     ack;
        logic                ok;
        logic                typed; // expectation written in the row
        t_result             want;
    } t_plan_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          i_cmd;
    logic [HANDLE_W-1:0] i_payload_handle;
    logic [LENGTH_W-1:0] i_payload_length;
    logic [ID_W-1:0]     i_ack_id;
    logic                i_ack_ok;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [WIN_W-1:0]    i_cfg_window_size;
    logic                o_strobe;
    logic                o_out_kind;
    logic [ID_W-1:0]     o_send_id;
    logic [HANDLE_W-1:0] o_send_handle;
    logic [LENGTH_W-1:0] o_send_length;
    logic                o_timer_start;
    logic                o_timer_stop;
    logic                o_dropped;
    logic                o_last;

    // shadow of the sender window
    logic [WIN_W-1:0]    shadow_window;
    logic [ID_W-1:0]     ack_base;
    logic [ID_W-1:0]     send_next;
    logic [ID_W-1:0]     fill_next;
    logic [5:0]          base_slot;
    logic [DESC_W-1:0]   desc_shadow [BUF_DEPTH];

    t_result             step_out[$];
    t_result             result_backlog[$];
    t_plan_row           plan[$];
    int                  mismatches = 0;

    go_back_n_sender_window u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_cmd             (i_cmd),
        .i_payload_handle  (i_payload_handle),
        .i_payload_length  (i_payload_length),
        .i_ack_id          (i_ack_id),
        .i_ack_ok          (i_ack_ok),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_window_size (i_cfg_window_size),
        .o_strobe          (o_strobe),
        .o_out_kind        (o_out_kind),
        .o_send_id         (o_send_id),
        .o_send_handle     (o_send_handle),
        .o_send_length     (o_send_length),
        .o_timer_start     (o_timer_start),
        .o_timer_stop      (o_timer_stop),
        .o_dropped         (o_dropped),
        .o_last            (o_last)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic void step_add(input t_result r);
        step_out.insert(step_out.size(), r);
    endfunction

    function automatic void backlog_add(input t_result r);
        result_backlog.insert(result_backlog.size(), r);
    endfunction

    function automatic t_result backlog_take();
        t_result r;
        r = result_backlog[0];
        result_backlog.delete(0);
        return r;
    endfunction

    function automatic void plan_add(input t_plan_row p);
        plan.insert(plan.size(), p);
    endfunction

    function automatic logic [5:0] slot_of(input logic [ID_W-1:0] id);
        logic [ID_W-1:0] off;
        off = id - ack_base;
        return base_slot + off[5:0];
    endfunction

    function automatic logic [ID_W-1:0] window_limit();
        if (shadow_window == '0) return ID_W'(1);
        if (shadow_window > WIN_MAX) return ID_W'(WIN_MAX);
        return ID_W'(shadow_window);
    endfunction

    function automatic t_result tx_item(input logic [ID_W-1:0] id, input logic st,
            input logic sp);
        t_result r;
        r = '0;
        r.kind = 1'b1;
        r.id = id;
        {r.handle, r.length} = desc_shadow[slot_of(id)];
        r.tstart = st;
        r.tstop = sp;
        return r;
    endfunction

    // Sends buffered packets while the window has room.
    function automatic void refill_window(input logic stop_first);
        logic [ID_W-1:0] w;
        w = window_limit();
        while ((send_next - ack_base) < w && send_next != fill_next) begin
            step_add(tx_item(send_next, send_next == ack_base,
                             stop_first && step_out.size() == 0));
            send_next++;
        end
    endfunction

    function automatic void advance_window(input logic [1:0] c, input logic [HANDLE_W-1:0] h,
            input logic [LENGTH_W-1:0] l, input logic [ID_W-1:0] a, input logic ok);
        logic [ID_W-1:0] adv;
        logic [ID_W-1:0] n;
        logic            st;
        logic            sp;
        logic            dr;
        t_result         r;
        int              i;
        st = 1'b0;
        sp = 1'b0;
        dr = 1'b0;
        step_out.delete();
        case (c)
            CMD_NEW: begin
                if ((fill_next - ack_base) >= BUF_DEPTH) begin
                    dr = 1'b1;
                end else begin
                    desc_shadow[slot_of(fill_next)] = {h, l};
                    fill_next++;
                    refill_window(1'b0);
                end
            end
            CMD_ACK: begin
                adv = a - (ack_base - 1);
                n = send_next - ack_base;
                if (ok && adv >= 1 && adv <= n) begin
                    base_slot = base_slot + adv[5:0];
                    ack_base = a + 1;
                    sp = (ack_base == send_next);
                    refill_window(sp);
                end
            end
            CMD_TIMEOUT: begin
                st = 1'b1;
                n = send_next - ack_base;
                for (i = 0; i < n && i < WIN_MAX; i++)
                    step_add(tx_item(ack_base + i, i == 0, 1'b0));
            end
            default: ;
        endcase
        if (step_out.size() == 0) begin
            r = '0;
            r.tstart = st;
            r.tstop = sp;
            r.drop = dr;
            step_add(r);
        end
        step_out[step_out.size() - 1].last = 1'b1;
    endfunction

    function automatic t_result stat(input logic st, input logic sp, input logic dr);
        t_result r;
        r = '0;
        r.tstart = st;
        r.tstop = sp;
        r.drop = dr;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic t_result sent(input logic [ID_W-1:0] id, input logic [HANDLE_W-1:0] h,
            input logic [LENGTH_W-1:0] l, input logic st, input logic sp);
        t_result r;
        r = '0;
        r.kind = 1'b1;
        r.id = id;
        r.handle = h;
        r.length = l;
        r.tstart = st;
        r.tstop = sp;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic t_plan_row row(input logic [1:0] c, input logic [HANDLE_W-1:0] h,
            input logic [LENGTH_W-1:0] l, input logic [ID_W-1:0] a, input logic ok,
            input logic typed, input t_result want);
        t_plan_row p;
        p = '0;
        p.cmd = c;
        p.hnd = h;
        p.len = l;
        p.ack = a;
        p.ok = ok;
        p.typed = typed;
        p.want = want;
        return p;
    endfunction

    function automatic t_plan_row cfg_row(input logic [WIN_W-1:0] w);
        t_plan_row p;
        p = '0;
        p.cfg = 1'b1;
        p.win = w;
        return p;
    endfunction

    function automatic void check_field(input string name, input logic [ID_W-1:0] want,
            input logic [ID_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // One command transaction; the shadow is advanced at the accepting edge.
    task automatic issue(input logic [1:0] c, input logic [HANDLE_W-1:0] h,
            input logic [LENGTH_W-1:0] l, input logic [ID_W-1:0] a, input logic ok,
            input logic typed, input t_result want, input int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_cmd = c;
        i_payload_handle = h;
        i_payload_length = l;
        i_ack_id = a;
        i_ack_ok = ok;
        start = 1'b1;
        do @(posedge i_clk); while (busy);
        advance_window(c, h, l, a, ok);
        if (typed)
            backlog_add(want);
        else
            foreach (step_out[i]) backlog_add(step_out[i]);
    endtask

    // Register write, only once the block has gone idle.
    task automatic write_window(input logic [WIN_W-1:0] w, input int gap);
        @(negedge i_clk);
        start = 1'b0;
        while (result_backlog.size() != 0 || busy) @(negedge i_clk);
        repeat (gap) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_window_size = w;
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow_window = w;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (result_backlog.size() == 0) begin
                $error("result with nothing pending: kind %0d id 0x%0h", o_out_kind, o_send_id);
                mismatches++;
            end else begin
                want = backlog_take();
                check_field("out_kind", want.kind, o_out_kind);
                check_field("send_id", want.id, o_send_id);
                check_field("send_handle", want.handle, o_send_handle);
                check_field("send_length", want.length, o_send_length);
                check_field("timer_start", want.tstart, o_timer_start);
                check_field("timer_stop", want.tstop, o_timer_stop);
                check_field("dropped", want.drop, o_dropped);
                check_field("last", want.last, o_last);
            end
        end
    end

    initial begin : stimulus
        logic [WIN_W-1:0]    win_pick [10];
        logic [1:0]          c;
        logic [HANDLE_W-1:0] h;
        logic [LENGTH_W-1:0] l;
        logic [ID_W-1:0]     a;
        logic                ok;
        logic                fill;
        logic                no_gaps;
        logic [WIN_W-1:0]    w;
        int                  r;
        int                  k;
        int                  phase;
        int                  counted;
        int                  phase_len;

        win_pick = '{5'd16, 5'd2, 5'd31, 5'd0, 5'd5, 5'd1, 5'd17, 5'd8, 5'd3, 5'd15};
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = CMD_NEW;
        i_payload_handle = '0;
        i_payload_length = '0;
        i_ack_id = '0;
        i_ack_ok = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_window_size = '0;
        shadow_window = WINDOW_RESET;
        ack_base = ID_RESET;
        send_next = ID_RESET;
        fill_next = ID_RESET;
        base_slot = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // idle timeout, unknown command, acks with nothing sent
        plan_add(row(CMD_TIMEOUT, 16'h0, 8'h0, 32'h0, 1'b0, 1'b1,
                     stat(1'b1, 1'b0, 1'b0)));
        plan_add(row(CMD_UNKNOWN, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1,
                     stat(1'b0, 1'b0, 1'b0)));
        plan_add(row(CMD_ACK, 16'h0, 8'h0, 32'd1, 1'b1, 1'b1, stat(1'b0, 1'b0, 1'b0)));
        // field extremes, zero length
        plan_add(row(CMD_NEW, 16'hFFFF, 8'hFF, 32'h0, 1'b0, 1'b1,
                     sent(32'd1, 16'hFFFF, 8'hFF, 1'b1, 1'b0)));
        plan_add(row(CMD_NEW, 16'h0, 8'h0, 32'hFFFF_FFFF, 1'b1, 1'b1,
                     sent(32'd2, 16'h0, 8'h0, 1'b0, 1'b0)));
        plan_add(row(CMD_NEW, 16'h5A5A, 8'h01, 32'h0, 1'b0, 1'b0, '0));
        // bad checksum, stale, beyond sent
        plan_add(row(CMD_ACK, 16'h0, 8'h0, 32'd2, 1'b0, 1'b1, stat(1'b0, 1'b0, 1'b0)));
        plan_add(row(CMD_ACK, 16'h0, 8'h0, 32'd0, 1'b1, 1'b1, stat(1'b0, 1'b0, 1'b0)));
        plan_add(row(CMD_ACK, 16'h0, 8'h0, 32'hFFFF_FFFF, 1'b1, 1'b1,
                     stat(1'b0, 1'b0, 1'b0)));
        plan_add(row(CMD_TIMEOUT, 16'h0, 8'h0, 32'h0, 1'b0, 1'b0, '0));
        plan_add(row(CMD_ACK, 16'h0, 8'h0, 32'd1, 1'b1, 1'b0, '0));
        plan_add(row(CMD_ACK, 16'h0, 8'h0, 32'd3, 1'b1, 1'b1, stat(1'b0, 1'b1, 1'b0)));
        // window 0 clamps to 1: stop rides on the refill that restarts the timer
        plan_add(cfg_row(5'd0));
        plan_add(row(CMD_NEW, 16'hA5A5, 8'h80, 32'h0, 1'b0, 1'b1,
                     sent(32'd4, 16'hA5A5, 8'h80, 1'b1, 1'b0)));
        plan_add(row(CMD_NEW, 16'h1234, 8'h10, 32'h0, 1'b0, 1'b0, '0));
        plan_add(row(CMD_NEW, 16'h4321, 8'h20, 32'h0, 1'b0, 1'b0, '0));
        plan_add(row(CMD_ACK, 16'h0, 8'h0, 32'd4, 1'b1, 1'b0, '0));
        plan_add(row(CMD_TIMEOUT, 16'h0, 8'h0, 32'h0, 1'b0, 1'b0, '0));
        plan_add(row(CMD_ACK, 16'h0, 8'h0, 32'd5, 1'b1, 1'b0, '0));
        // window 31 clamps to the maximum
        plan_add(cfg_row(5'd31));
        plan_add(row(CMD_NEW, 16'hC3C3, 8'hFE, 32'h0, 1'b0, 1'b0, '0));
        plan_add(row(CMD_ACK, 16'h0, 8'h0, 32'd7, 1'b1, 1'b1, stat(1'b0, 1'b1, 1'b0)));

        foreach (plan[i]) begin
            if (plan[i].cfg)
                write_window(plan[i].win, $urandom_range(0, MAX_GAP));
            else
                issue(plan[i].cmd, plan[i].hnd, plan[i].len, plan[i].ack, plan[i].ok,
                      plan[i].typed, plan[i].want, $urandom_range(0, MAX_GAP));
        end

        // random phases; the first one fills the store behind a window of one
        counted = 0;
        phase = 0;
        while (counted < TARGET) begin
            fill = (phase == 0) || ($urandom_range(0, 5) == 0);
            if (phase == 0)
                w = 5'd1;
            else if (phase % 10 == 9)
                w = WIN_W'($urandom_range(0, 31));
            else
                w = win_pick[phase % 10];
            write_window(w, $urandom_range(0, MAX_GAP));
            no_gaps = ($urandom_range(0, 3) == 0);
            phase_len = fill ? 100 : 30;
            for (k = 0; k < phase_len && counted < TARGET; k++) begin
                h = HANDLE_W'($urandom_range(0, 16'hFFFF));
                l = LENGTH_W'($urandom_range(0, 8'hFF));
                a = $urandom;
                ok = 1'($urandom_range(0, 1));
                r = $urandom_range(0, 99);
                if (r < (fill ? 90 : 40)) begin
                    c = CMD_NEW;
                end else if (r < (fill ? 96 : 65) && send_next != ack_base) begin
                    c = CMD_ACK;
                    ok = 1'b1;
                    a = ack_base - 1 + $urandom_range(1, send_next - ack_base);
                end else if (fill || r < 75) begin
                    c = CMD_TIMEOUT;
                end else begin
                    if (r >= 94) begin
                        c = CMD_UNKNOWN;
                    end else begin
                        c = CMD_ACK;
                        case ($urandom_range(0, 3))
                            0: begin
                                ok = 1'b0;
                                a = ack_base - 1 + $urandom_range(0, 4);
                            end
                            1: begin
                                ok = 1'b1;
                                a = ack_base - 1 - $urandom_range(0, 3);
                            end
                            2: begin
                                ok = 1'b1;
                                a = send_next + $urandom_range(0, 3);
                            end
                            default: ;  // random id, random checksum flag
                        endcase
                    end
                end
                issue(c, h, l, a, ok, 1'b0, '0, no_gaps ? 0 : $urandom_range(0, MAX_GAP));
                counted++;
            end
            phase++;
        end

        @(negedge i_clk);
        start = 1'b0;
        while (result_backlog.size() != 0 || busy) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (mismatches == 0 && result_backlog.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
